@@ sv/ctl_pkg.sv @@
// Shared types, constants and helper functions of the token lexer.
package ctl_pkg;

	localparam int VALUE_BITS = 32;
	localparam int LINE_BITS = 16;
	localparam int KIND_BITS = 6;
	localparam int LEN_BITS = 8;
	localparam int CHAR_BITS = 8;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW = $clog2(FIFO_DEPTH);

	localparam logic [VALUE_BITS-1:0] VALUE_MAX = {VALUE_BITS{1'b1}};
	localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};
	localparam logic [LEN_BITS-1:0] LEN_MAX = {LEN_BITS{1'b1}};

	typedef enum logic [1:0] {
		MODE_IDLE   = 2'd0,
		MODE_IDENT  = 2'd1,
		MODE_NUMBER = 2'd2,
		MODE_OPER   = 2'd3
	} mode_t;

	localparam logic [KIND_BITS-1:0] K_IDENT    = 6'd0;
	localparam logic [KIND_BITS-1:0] K_NUMBER   = 6'd1;
	localparam logic [KIND_BITS-1:0] K_ASSIGN   = 6'd2;
	localparam logic [KIND_BITS-1:0] K_PLUS     = 6'd3;
	localparam logic [KIND_BITS-1:0] K_MINUS    = 6'd4;
	localparam logic [KIND_BITS-1:0] K_STAR     = 6'd5;
	localparam logic [KIND_BITS-1:0] K_SLASH    = 6'd6;
	localparam logic [KIND_BITS-1:0] K_PERCENT  = 6'd7;
	localparam logic [KIND_BITS-1:0] K_LPAREN   = 6'd8;
	localparam logic [KIND_BITS-1:0] K_RPAREN   = 6'd9;
	localparam logic [KIND_BITS-1:0] K_LBRACE   = 6'd10;
	localparam logic [KIND_BITS-1:0] K_RBRACE   = 6'd11;
	localparam logic [KIND_BITS-1:0] K_LBRACK   = 6'd12;
	localparam logic [KIND_BITS-1:0] K_RBRACK   = 6'd13;
	localparam logic [KIND_BITS-1:0] K_SEMI     = 6'd14;
	localparam logic [KIND_BITS-1:0] K_COMMA    = 6'd15;
	localparam logic [KIND_BITS-1:0] K_AMP      = 6'd16;
	localparam logic [KIND_BITS-1:0] K_LT       = 6'd17;
	localparam logic [KIND_BITS-1:0] K_GT       = 6'd18;
	localparam logic [KIND_BITS-1:0] K_LE       = 6'd19;
	localparam logic [KIND_BITS-1:0] K_GE       = 6'd20;
	localparam logic [KIND_BITS-1:0] K_EQ       = 6'd21;
	localparam logic [KIND_BITS-1:0] K_NE       = 6'd22;
	localparam logic [KIND_BITS-1:0] K_IF       = 6'd23;
	localparam logic [KIND_BITS-1:0] K_ELSE     = 6'd24;
	localparam logic [KIND_BITS-1:0] K_WHILE    = 6'd25;
	localparam logic [KIND_BITS-1:0] K_DO       = 6'd26;
	localparam logic [KIND_BITS-1:0] K_FOR      = 6'd27;
	localparam logic [KIND_BITS-1:0] K_BREAK    = 6'd28;
	localparam logic [KIND_BITS-1:0] K_CONTINUE = 6'd29;
	localparam logic [KIND_BITS-1:0] K_RETURN   = 6'd30;
	localparam logic [KIND_BITS-1:0] K_INT      = 6'd31;
	localparam logic [KIND_BITS-1:0] K_NOT      = 6'd36;
	localparam logic [KIND_BITS-1:0] K_ANDAND   = 6'd37;
	localparam logic [KIND_BITS-1:0] K_OROR     = 6'd38;
	localparam logic [KIND_BITS-1:0] K_DEBUG    = 6'd39;
	localparam logic [KIND_BITS-1:0] K_EOF      = 6'd40;
	localparam logic [KIND_BITS-1:0] K_UNKNOWN  = 6'd41;

	typedef struct packed {
		logic [KIND_BITS-1:0]  kind;
		logic [LINE_BITS-1:0]  line;
		logic [VALUE_BITS-1:0] value;
		logic [LEN_BITS-1:0]   len;
		logic                  ovf;
		logic                  last;
	} token_t;

	// one classified input word, with up to two tokens
	typedef struct packed {
		logic   v0;
		logic   v1;
		token_t t0;
		token_t t1;
	} pair_t;

	function automatic logic is_alpha(input logic [CHAR_BITS-1:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic is_digit(input logic [CHAR_BITS-1:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_space(input logic [CHAR_BITS-1:0] c);
		return c == " " || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic logic [KIND_BITS-1:0] ident_kind(input logic [63:0] p,
		input logic [LEN_BITS-1:0] n);
		logic [KIND_BITS-1:0] k;
		k = K_IDENT;
		if (n == 8'd2 && p[15:0] == 16'h6669) k = K_IF;
		if (n == 8'd4 && p[31:0] == 32'h65736c65) k = K_ELSE;
		if (n == 8'd5 && p[39:0] == 40'h656c696877) k = K_WHILE;
		if (n == 8'd2 && p[15:0] == 16'h6f64) k = K_DO;
		if (n == 8'd3 && p[23:0] == 24'h726f66) k = K_FOR;
		if (n == 8'd5 && p[39:0] == 40'h6b61657262) k = K_BREAK;
		if (n == 8'd8 && p == 64'h65756e69746e6f63) k = K_CONTINUE;
		if (n == 8'd6 && p[47:0] == 48'h6e7275746572) k = K_RETURN;
		if (n == 8'd3 && p[23:0] == 24'h746e69) k = K_INT;
		if (n == 8'd5 && p[39:0] == 40'h6775626564) k = K_DEBUG;
		return k;
	endfunction

	function automatic logic [KIND_BITS-1:0] single_kind(input logic [CHAR_BITS-1:0] c);
		logic [KIND_BITS-1:0] k;
		case (c)
			"=": k = K_ASSIGN;
			"<": k = K_LT;
			">": k = K_GT;
			"!": k = K_NOT;
			"&": k = K_AMP;
			"+": k = K_PLUS;
			"-": k = K_MINUS;
			"*": k = K_STAR;
			"/": k = K_SLASH;
			"%": k = K_PERCENT;
			"(": k = K_LPAREN;
			")": k = K_RPAREN;
			"{": k = K_LBRACE;
			"}": k = K_RBRACE;
			"[": k = K_LBRACK;
			"]": k = K_RBRACK;
			";": k = K_SEMI;
			",": k = K_COMMA;
			default: k = K_UNKNOWN;
		endcase
		return k;
	endfunction

	function automatic logic [KIND_BITS-1:0] double_kind(input logic [CHAR_BITS-1:0] c);
		logic [KIND_BITS-1:0] k;
		case (c)
			"=": k = K_EQ;
			"<": k = K_LE;
			">": k = K_GE;
			"!": k = K_NE;
			"&": k = K_ANDAND;
			default: k = K_OROR;
		endcase
		return k;
	endfunction

endpackage

@@ sv/ctl_front.sv @@
// Front end: scans one byte a cycle while take is high and classifies it into at most two tokens.
module ctl_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         take,
	input  logic [ctl_pkg::CHAR_BITS-1:0] c,
	input  logic                         eoi,
	output ctl_pkg::pair_t               pair
);

	ctl_pkg::mode_t                   mode_q, mode_d;
	logic [ctl_pkg::CHAR_BITS-1:0]    op_q, op_d;
	logic [63:0]                      pfx_q, pfx_d;
	logic [ctl_pkg::LEN_BITS-1:0]     cnt_q, cnt_d;
	logic [ctl_pkg::VALUE_BITS-1:0]   acc_q, acc_d;
	logic                             sat_q, sat_d;
	logic [ctl_pkg::LINE_BITS-1:0]    line_q, line_d;

	logic                             at_end, flush, two_ok;
	ctl_pkg::token_t                  ft, st;
	logic                             fv, sv;
	logic [ctl_pkg::VALUE_BITS+4:0]   prod;
	logic [ctl_pkg::VALUE_BITS-1:0]   dig;
	logic [ctl_pkg::KIND_BITS-1:0]    sk;

	always_comb begin
		dig = {{(ctl_pkg::VALUE_BITS-4){1'b0}}, c[3:0]};
		prod = {5'd0, acc_q} * (ctl_pkg::VALUE_BITS+5)'(10)
			+ {5'd0, dig};
	end

	always_comb begin
		mode_d = mode_q;
		op_d = op_q;
		pfx_d = pfx_q;
		cnt_d = cnt_q;
		acc_d = acc_q;
		sat_d = sat_q;
		line_d = line_q;
		at_end = eoi || c == '0;
		two_ok = (c == "=" && op_q != "&" && op_q != "|") ||
			(c == "&" && op_q == "&") || (c == "|" && op_q == "|");
		flush = 1'b0;
		fv = 1'b0;
		sv = 1'b0;
		ft = '0;
		st = '0;
		ft.line = line_q;
		st.line = line_q;
		sk = ctl_pkg::single_kind(c);

		case (mode_q)
			ctl_pkg::MODE_IDENT: begin
				ft.kind = ctl_pkg::ident_kind(pfx_q, cnt_q);
				ft.len = cnt_q;
			end
			ctl_pkg::MODE_NUMBER: begin
				ft.kind = ctl_pkg::K_NUMBER;
				ft.value = acc_q;
				ft.ovf = sat_q;
			end
			ctl_pkg::MODE_OPER: begin
				ft.kind = ctl_pkg::single_kind(op_q);
				if (ft.kind == ctl_pkg::K_UNKNOWN)
					ft.value = {{(ctl_pkg::VALUE_BITS-8){1'b0}}, op_q};
			end
			default: ft.kind = ctl_pkg::K_EOF;
		endcase

		if (at_end) begin
			flush = 1'b1;
			sv = 1'b1;
			st.kind = ctl_pkg::K_EOF;
		end else if (mode_q == ctl_pkg::MODE_IDENT &&
			(ctl_pkg::is_alpha(c) || ctl_pkg::is_digit(c) || c == "_")) begin
			if (cnt_q < 8'd8) pfx_d = pfx_q | ({56'd0, c} << {cnt_q[2:0], 3'b000});
			if (cnt_q != ctl_pkg::LEN_MAX) cnt_d = cnt_q + 1'b1;
		end else if (mode_q == ctl_pkg::MODE_NUMBER && ctl_pkg::is_digit(c)) begin
			if (prod[ctl_pkg::VALUE_BITS+4:ctl_pkg::VALUE_BITS] != '0) begin
				acc_d = ctl_pkg::VALUE_MAX;
				sat_d = 1'b1;
			end else begin
				acc_d = prod[ctl_pkg::VALUE_BITS-1:0];
			end
		end else if (mode_q == ctl_pkg::MODE_OPER && two_ok) begin
			fv = 1'b1;
			ft.kind = ctl_pkg::double_kind(op_q);
			ft.value = '0;
			mode_d = ctl_pkg::MODE_IDLE;
			op_d = '0;
		end else begin
			flush = 1'b1;
			if (ctl_pkg::is_space(c)) begin
				if (c == 8'd10 && line_q != ctl_pkg::LINE_MAX) line_d = line_q + 1'b1;
			end else if (ctl_pkg::is_alpha(c) || ctl_pkg::is_digit(c) || c == "=" ||
				c == "<" || c == ">" || c == "!" || c == "&" || c == "|") begin
				// handled after flush below
			end else begin
				sv = 1'b1;
				st.kind = sk;
				if (sk == ctl_pkg::K_UNKNOWN)
					st.value = {{(ctl_pkg::VALUE_BITS-8){1'b0}}, c};
			end
		end

		if (flush) begin
			fv = mode_q != ctl_pkg::MODE_IDLE;
			mode_d = ctl_pkg::MODE_IDLE;
			op_d = '0;
			pfx_d = '0;
			cnt_d = '0;
			acc_d = '0;
			sat_d = 1'b0;
			if (at_end) begin
				line_d = {{(ctl_pkg::LINE_BITS-1){1'b0}}, 1'b1};
			end else if (ctl_pkg::is_alpha(c)) begin
				mode_d = ctl_pkg::MODE_IDENT;
				pfx_d = {56'd0, c};
				cnt_d = 8'd1;
			end else if (ctl_pkg::is_digit(c)) begin
				mode_d = ctl_pkg::MODE_NUMBER;
				acc_d = dig;
			end else if (c == "=" || c == "<" || c == ">" || c == "!" || c == "&" ||
				c == "|") begin
				mode_d = ctl_pkg::MODE_OPER;
				op_d = c;
			end
		end

		ft.last = !sv;
		st.last = 1'b1;
		pair.v0 = fv || sv;
		pair.v1 = fv && sv;
		pair.t0 = fv ? ft : st;
		pair.t1 = st;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= ctl_pkg::MODE_IDLE;
			op_q <= '0;
			pfx_q <= '0;
			cnt_q <= '0;
			acc_q <= '0;
			sat_q <= 1'b0;
			line_q <= {{(ctl_pkg::LINE_BITS-1){1'b0}}, 1'b1};
		end else if (take) begin
			mode_q <= mode_d;
			op_q <= op_d;
			pfx_q <= pfx_d;
			cnt_q <= cnt_d;
			acc_q <= acc_d;
			sat_q <= sat_d;
			line_q <= line_d;
		end
	end

	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		pair.v1 |-> pair.v0)
		else $error("second token without first");
	a_idle_count: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == ctl_pkg::MODE_IDLE |-> cnt_q == '0)
		else $error("idle with identifier count");
	a_line_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		line_q != '0)
		else $error("line count zero");

endmodule

@@ sv/ctl_back.sv @@
// Back end: token queue that takes up to two tokens a cycle while room is high and pops one.
module ctl_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr,
	input  ctl_pkg::pair_t pair,
	output logic           room,
	input  logic           rd,
	output logic           nonempty,
	output ctl_pkg::token_t head
);

	ctl_pkg::token_t             mem_q [ctl_pkg::FIFO_DEPTH];
	logic [ctl_pkg::FIFO_AW-1:0] wp_q, rp_q;
	logic [ctl_pkg::FIFO_AW:0]   cnt_q;
	logic [ctl_pkg::FIFO_AW:0]   nin, nout;

	always_comb begin
		nonempty = cnt_q != '0;
		nin = wr ? ({{ctl_pkg::FIFO_AW{1'b0}}, pair.v0} + {{ctl_pkg::FIFO_AW{1'b0}}, pair.v1})
			: '0;
		nout = {{ctl_pkg::FIFO_AW{1'b0}}, rd && nonempty};
		room = cnt_q <= (ctl_pkg::FIFO_AW+1)'(ctl_pkg::FIFO_DEPTH - 2);
		head = mem_q[rp_q];
	end

	always_ff @(posedge clk) begin
		if (wr && pair.v0) mem_q[wp_q] <= pair.t0;
		if (wr && pair.v1) mem_q[wp_q + 1'b1] <= pair.t1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			wp_q <= wp_q + nin[ctl_pkg::FIFO_AW-1:0];
			rp_q <= rp_q + nout[ctl_pkg::FIFO_AW-1:0];
			cnt_q <= cnt_q + nin - nout;
		end
	end

	a_not_overfilled: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (ctl_pkg::FIFO_AW+1)'(ctl_pkg::FIFO_DEPTH))
		else $error("queue overfilled");
	a_write_room: assert property (@(posedge clk) disable iff (!arst_n)
		(wr && nin != '0) |-> room)
		else $error("write without room");
	a_pointers: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_pkg::FIFO_AW'(wp_q - rp_q) == cnt_q[ctl_pkg::FIFO_AW-1:0])
		else $error("pointer mismatch");

endmodule

@@ sv/c_like_token_lexer.sv @@
// Top level of the byte-serial token lexer.
// Takes one source byte per cycle (push when not full) and queues up to two tokens per
// byte in a four-entry token queue; full rises when fewer than two entries are free, so
// one byte a cycle flows as long as tokens are popped as fast as they are made. A
// token shows on the result ports while empty is low, with last_of_item marking the
// final token of its byte.
module c_like_token_lexer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  char_code,
	input  logic        end_of_input,
	output logic        empty,
	input  logic        pop,
	output logic [5:0]  token_kind,
	output logic [15:0] line_number,
	output logic [31:0] token_value,
	output logic [7:0]  ident_length,
	output logic        value_overflow,
	output logic        last_of_item
);

	ctl_pkg::pair_t  pair;
	ctl_pkg::token_t head;
	logic            room, nonempty, take;

	assign take = push && room;
	assign full = !room;
	assign empty = !nonempty;

	ctl_front u_front (
		.clk(clk), .arst_n(arst_n), .take(take), .c(char_code), .eoi(end_of_input),
		.pair(pair)
	);

	ctl_back u_back (
		.clk(clk), .arst_n(arst_n), .wr(take), .pair(pair), .room(room),
		.rd(pop), .nonempty(nonempty), .head(head)
	);

	assign token_kind = head.kind;
	assign line_number = head.line;
	assign token_value = head.value;
	assign ident_length = head.len;
	assign value_overflow = head.ovf;
	assign last_of_item = head.last;

endmodule

@@ bench/tb_c_like_token_lexer.sv @@
// Self-checking bench for the token lexer: table-driven directed bytes, keyword text, a pop stall, random source text.
module tb_c_like_token_lexer;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [7:0] ch;
		logic       eoi;
		logic       chk;
		logic [5:0] kind;
		logic [31:0] val;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic [7:0]  char_code = 8'd0;
	logic        end_of_input = 1'b0;
	logic        empty;
	logic        pop = 1'b0;
	logic [5:0]  token_kind;
	logic [15:0] line_number;
	logic [31:0] token_value;
	logic [7:0]  ident_length;
	logic        value_overflow;
	logic        last_of_item;

	c_like_token_lexer uut (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	ctl_pkg::token_t tok_expected[$];
	dir_row_t        stim_table[$];
	int              errors = 0;
	int              tokens_seen = 0;
	int              bytes_sent = 0;
	longint          cycles = 0;
	bit              quiet = 1'b0;
	bit              hold_pop = 1'b0;

	ctl_pkg::mode_t  lx_mode;
	logic [7:0]      lx_op;
	logic [63:0]     lx_prefix;
	logic [7:0]      lx_count;
	logic [31:0]     lx_num;
	logic            lx_sat;
	logic [15:0]     lx_line;

	function automatic bit alpha_c(logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
	endfunction

	function automatic bit digit_c(logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic [5:0] keyword_of(logic [63:0] p, logic [7:0] n);
		case (n)
			8'd2: begin
				if (p[15:0] == {"f", "i"}) return ctl_pkg::K_IF;
				if (p[15:0] == {"o", "d"}) return ctl_pkg::K_DO;
			end
			8'd3: begin
				if (p[23:0] == {"r", "o", "f"}) return ctl_pkg::K_FOR;
				if (p[23:0] == {"t", "n", "i"}) return ctl_pkg::K_INT;
			end
			8'd4: if (p[31:0] == {"e", "s", "l", "e"}) return ctl_pkg::K_ELSE;
			8'd5: begin
				if (p[39:0] == {"e", "l", "i", "h", "w"}) return ctl_pkg::K_WHILE;
				if (p[39:0] == {"k", "a", "e", "r", "b"}) return ctl_pkg::K_BREAK;
				if (p[39:0] == {"g", "u", "b", "e", "d"}) return ctl_pkg::K_DEBUG;
			end
			8'd6: if (p[47:0] == {"n", "r", "u", "t", "e", "r"}) return ctl_pkg::K_RETURN;
			8'd8: if (p == {"e", "u", "n", "i", "t", "n", "o", "c"}) return ctl_pkg::K_CONTINUE;
			default: ;
		endcase
		return ctl_pkg::K_IDENT;
	endfunction

	task automatic queue_token(inout ctl_pkg::token_t batch[$], input logic [5:0] k,
		input logic [31:0] v, input logic [7:0] n, input logic o);
		ctl_pkg::token_t t;
		t.kind = k;
		t.line = lx_line;
		t.value = v;
		t.len = n;
		t.ovf = o;
		t.last = 1'b0;
		batch = {batch, t};
	endtask

	task automatic flush_pending(inout ctl_pkg::token_t batch[$]);
		logic [5:0] k;
		case (lx_mode)
			ctl_pkg::MODE_IDENT:
				queue_token(batch, keyword_of(lx_prefix, lx_count), 32'd0, lx_count, 1'b0);
			ctl_pkg::MODE_NUMBER: queue_token(batch, ctl_pkg::K_NUMBER, lx_num, 8'd0, lx_sat);
			ctl_pkg::MODE_OPER: begin
				case (lx_op)
					"=": k = ctl_pkg::K_ASSIGN;
					"<": k = ctl_pkg::K_LT;
					">": k = ctl_pkg::K_GT;
					"!": k = ctl_pkg::K_NOT;
					"&": k = ctl_pkg::K_AMP;
					default: k = ctl_pkg::K_UNKNOWN;
				endcase
				queue_token(batch, k, k == ctl_pkg::K_UNKNOWN ? {24'd0, lx_op} : 32'd0,
					8'd0, 1'b0);
			end
			default: ;
		endcase
		lx_mode = ctl_pkg::MODE_IDLE;
		lx_op = '0;
		lx_prefix = '0;
		lx_count = '0;
		lx_num = '0;
		lx_sat = 1'b0;
	endtask

	task automatic add_digit(logic [7:0] c);
		logic [35:0] wide;
		wide = lx_num * 36'd10 + (c - 8'h30);
		if (wide > 36'hFFFFFFFF) begin
			lx_num = ctl_pkg::VALUE_MAX;
			lx_sat = 1'b1;
		end else
			lx_num = wide[31:0];
	endtask

	task automatic add_letter(logic [7:0] c);
		if (lx_count < 8'd8) lx_prefix[8*lx_count +: 8] = c;
		if (lx_count < 8'd255) lx_count++;
	endtask

	task automatic scan_fresh(inout ctl_pkg::token_t batch[$], input logic [7:0] c);
		logic [5:0] k;
		if (c == 8'h20 || (c >= 8'd9 && c <= 8'd13)) begin
			if (c == 8'd10 && lx_line != ctl_pkg::LINE_MAX) lx_line++;
		end else if (alpha_c(c)) begin
			lx_mode = ctl_pkg::MODE_IDENT;
			add_letter(c);
		end else if (digit_c(c)) begin
			lx_mode = ctl_pkg::MODE_NUMBER;
			add_digit(c);
		end else if (c inside {"=", "<", ">", "!", "&", "|"}) begin
			lx_mode = ctl_pkg::MODE_OPER;
			lx_op = c;
		end else begin
			case (c)
				"+": k = ctl_pkg::K_PLUS;
				"-": k = ctl_pkg::K_MINUS;
				"*": k = ctl_pkg::K_STAR;
				"/": k = ctl_pkg::K_SLASH;
				"%": k = ctl_pkg::K_PERCENT;
				"(": k = ctl_pkg::K_LPAREN;
				")": k = ctl_pkg::K_RPAREN;
				"{": k = ctl_pkg::K_LBRACE;
				"}": k = ctl_pkg::K_RBRACE;
				"[": k = ctl_pkg::K_LBRACK;
				"]": k = ctl_pkg::K_RBRACK;
				";": k = ctl_pkg::K_SEMI;
				",": k = ctl_pkg::K_COMMA;
				default: k = ctl_pkg::K_UNKNOWN;
			endcase
			queue_token(batch, k, k == ctl_pkg::K_UNKNOWN ? {24'd0, c} : 32'd0, 8'd0, 1'b0);
		end
	endtask

	task automatic lex_byte(input logic [7:0] c, input logic eoi,
		output ctl_pkg::token_t batch[$]);
		logic [5:0] k;
		batch = {};
		if (eoi || c == 8'd0) begin
			flush_pending(batch);
			queue_token(batch, ctl_pkg::K_EOF, 32'd0, 8'd0, 1'b0);
			lx_line = 16'd1;
		end else if (lx_mode == ctl_pkg::MODE_IDENT && (alpha_c(c) || digit_c(c) || c == "_"))
			add_letter(c);
		else if (lx_mode == ctl_pkg::MODE_NUMBER && digit_c(c))
			add_digit(c);
		else if (lx_mode == ctl_pkg::MODE_OPER && ((c == "=" && lx_op != "&" && lx_op != "|") ||
			(c == "&" && lx_op == "&") || (c == "|" && lx_op == "|"))) begin
			case (lx_op)
				"=": k = ctl_pkg::K_EQ;
				"<": k = ctl_pkg::K_LE;
				">": k = ctl_pkg::K_GE;
				"!": k = ctl_pkg::K_NE;
				"&": k = ctl_pkg::K_ANDAND;
				default: k = ctl_pkg::K_OROR;
			endcase
			queue_token(batch, k, 32'd0, 8'd0, 1'b0);
			lx_mode = ctl_pkg::MODE_IDLE;
			lx_op = '0;
		end else begin
			flush_pending(batch);
			scan_fresh(batch, c);
		end
		if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
	endtask

	task automatic send_word(input logic [7:0] c, input logic eoi, input bit chk,
		input logic [5:0] k, input logic [31:0] v);
		ctl_pkg::token_t batch[$];
		if (!quiet && $urandom_range(0, 5) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 11)) @(negedge clk);
		end
		push <= 1'b1;
		char_code <= c;
		end_of_input <= eoi;
		do @(posedge clk); while (full);
		lex_byte(c, eoi, batch);
		if (chk) begin
			if (batch.size() == 0) begin
				$error("directed row byte %0d: token_kind exp %0d act none", c, k);
				errors++;
			end else begin
				if (batch[0].kind != k) begin
					$error("directed row byte %0d: token_kind exp %0d act %0d", c, k,
						batch[0].kind);
					errors++;
				end
				if (batch[0].value != v) begin
					$error("directed row byte %0d: token_value exp %0d act %0d", c, v,
						batch[0].value);
					errors++;
				end
			end
		end
		tok_expected = {tok_expected, batch};
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_plain(input logic [7:0] c);
		send_word(c, 1'b0, 1'b0, 6'd0, 32'd0);
	endtask

	task automatic add_row(logic [7:0] c, logic e, logic chk, logic [5:0] k, logic [31:0] v);
		dir_row_t r;
		r.ch = c; r.eoi = e; r.chk = chk; r.kind = k; r.val = v;
		stim_table = {stim_table, r};
	endtask

	function automatic logic [7:0] pick_char();
		case ($urandom_range(0, 9))
			0, 1: return 8'h61 + 8'($urandom_range(0, 25));
			2: return 8'h41 + 8'($urandom_range(0, 25));
			3, 4: return 8'h30 + 8'($urandom_range(0, 9));
			5: return " ";
			6: return 8'd10;
			7: begin
				case ($urandom_range(0, 7))
					0: return "=";
					1: return "<";
					2: return ">";
					3: return "!";
					4: return "&";
					5: return "|";
					6: return "_";
					default: return 8'd9 + 8'($urandom_range(0, 4));
				endcase
			end
			8: begin
				case ($urandom_range(0, 12))
					0: return "+"; 1: return "-"; 2: return "*"; 3: return "/";
					4: return "%"; 5: return "("; 6: return ")"; 7: return "{";
					8: return "}"; 9: return "["; 10: return "]"; 11: return ";";
					default: return ",";
				endcase
			end
			default: return $urandom_range(0, 60) == 0 ? 8'd0 : 8'($urandom_range(1, 255));
		endcase
	endfunction

	// result side
	initial begin
		ctl_pkg::token_t exp_tok;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_pop || (!quiet && $urandom_range(0, 5) == 0)) begin
				pop <= 1'b0;
				if (!hold_pop) repeat ($urandom_range(1, 11)) @(negedge clk);
			end else begin
				pop <= 1'b1;
				@(posedge clk);
				if (!empty) begin
					tokens_seen++;
					if (tok_expected.size() == 0) begin
						$error("token with nothing expected: kind %0d", token_kind);
						errors++;
					end else begin
						exp_tok = tok_expected.pop_front();
						if (token_kind !== exp_tok.kind) begin
							$error("token_kind exp %0d act %0d", exp_tok.kind, token_kind);
							errors++;
						end
						if (line_number !== exp_tok.line) begin
							$error("line_number exp %0d act %0d", exp_tok.line, line_number);
							errors++;
						end
						if (token_value !== exp_tok.value) begin
							$error("token_value exp %0d act %0d", exp_tok.value, token_value);
							errors++;
						end
						if (ident_length !== exp_tok.len) begin
							$error("ident_length exp %0d act %0d", exp_tok.len, ident_length);
							errors++;
						end
						if (value_overflow !== exp_tok.ovf) begin
							$error("value_overflow exp %0d act %0d", exp_tok.ovf,
								value_overflow);
							errors++;
						end
						if (last_of_item !== exp_tok.last) begin
							$error("last_of_item exp %0d act %0d", exp_tok.last, last_of_item);
							errors++;
						end
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 200000) begin
			$display("timeout after %0d cycles", cycles);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		string s;
		int wait_n;
		lx_mode = ctl_pkg::MODE_IDLE;
		lx_op = '0; lx_prefix = '0; lx_count = '0; lx_num = '0; lx_sat = 1'b0;
		lx_line = 16'd1;
		add_row("+", 1'b0, 1'b1, ctl_pkg::K_PLUS, 32'd0);
		add_row(8'hFF, 1'b0, 1'b1, ctl_pkg::K_UNKNOWN, 32'd255);
		add_row(8'h80, 1'b0, 1'b1, ctl_pkg::K_UNKNOWN, 32'd128);
		add_row("_", 1'b0, 1'b1, ctl_pkg::K_UNKNOWN, 32'd95);
		add_row("|", 1'b0, 1'b0, 6'd0, 32'd0);
		add_row("a", 1'b0, 1'b1, ctl_pkg::K_UNKNOWN, 32'd124);
		add_row("|", 1'b0, 1'b0, 6'd0, 32'd0);
		add_row("|", 1'b0, 1'b1, ctl_pkg::K_OROR, 32'd0);
		add_row("&", 1'b0, 1'b0, 6'd0, 32'd0);
		add_row("&", 1'b0, 1'b1, ctl_pkg::K_ANDAND, 32'd0);
		add_row("!", 1'b0, 1'b0, 6'd0, 32'd0);
		add_row("=", 1'b0, 1'b1, ctl_pkg::K_NE, 32'd0);
		add_row("1", 1'b0, 1'b0, 6'd0, 32'd0);
		add_row("2", 1'b0, 1'b0, 6'd0, 32'd0);
		add_row("x", 1'b0, 1'b1, ctl_pkg::K_NUMBER, 32'd12);
		add_row(8'd10, 1'b0, 1'b1, ctl_pkg::K_IDENT, 32'd0);
		add_row("<", 1'b0, 1'b0, 6'd0, 32'd0);
		add_row("8", 1'b1, 1'b1, ctl_pkg::K_LT, 32'd0);
		add_row(8'h00, 1'b1, 1'b1, ctl_pkg::K_EOF, 32'd0);
		add_row(8'h00, 1'b0, 1'b1, ctl_pkg::K_EOF, 32'd0);
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		foreach (stim_table[i])
			send_word(stim_table[i].ch, stim_table[i].eoi, stim_table[i].chk,
				stim_table[i].kind, stim_table[i].val);
		// keywords, saturating number, long identifier
		s = "if else while do for break continue return int debug =,==,<=,>= ";
		for (int i = 0; i < s.len(); i++) send_plain(s[i]);
		for (int i = 0; i < 12; i++) send_plain("9");
		send_plain(";");
		for (int i = 0; i < 256; i++) send_plain("q");
		send_word(8'd0, 1'b1, 1'b0, 6'd0, 32'd0);
		// long receiver stall while bytes keep coming
		fork
			begin
				hold_pop = 1'b1;
				repeat (60) @(negedge clk);
				hold_pop = 1'b0;
			end
			for (int i = 0; i < 30; i++) send_plain("+");
		join
		for (int i = 0; i < 265; i++) begin
			if (i > 200) quiet = 1'b1;
			send_word(pick_char(), $urandom_range(0, 80) == 0, 1'b0, 6'd0, 32'd0);
		end
		send_word(8'd0, 1'b1, 1'b0, 6'd0, 32'd0);
		push <= 1'b0;
		wait_n = 0;
		while (tok_expected.size() != 0 && wait_n < 5000) begin
			@(negedge clk);
			wait_n++;
		end
		repeat (20) @(negedge clk);
		$display("%0d bytes sent, %0d tokens checked, including keywords, overflow,", bytes_sent,
			tokens_seen);
		$display("long identifiers, two-char operators and a long output stall");
		if (errors == 0 && tok_expected.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
